// ===== design/ycc2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// ycc2rgb_pkg
// Shared types, register indexes, coefficient lookup and saturation for the
// YCbCr to RGBA pixel converter.
// ----------------------------------------------------------------------------
package ycc2rgb_pkg;

  localparam int SampleW = 8;
  localparam int IndexW  = 2;
  localparam int CfgW    = 2;
  localparam int CoefW   = 10;
  localparam int AccW    = 20;

  localparam logic [IndexW-1:0] CFG_IDX_FULL_RANGE = 2'd0;
  localparam logic [IndexW-1:0] CFG_IDX_MATRIX     = 2'd1;

  localparam logic [1:0] MAT_BT601  = 2'd0;
  localparam logic [1:0] MAT_BT2020 = 2'd1;
  localparam logic [1:0] MAT_BT709  = 2'd2;

  localparam logic [SampleW-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [SampleW-1:0] LUMA_FLOOR   = 8'd16;
  localparam logic [CoefW-1:0]   LUMA_GAIN    = 10'd298;

  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    logic [SampleW-1:0] luma;
    logic [SampleW-1:0] chroma_blue;
    logic [SampleW-1:0] chroma_red;
  } pixel_in_t;

  typedef struct packed {
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] green;
    logic [SampleW-1:0] blue;
    logic [SampleW-1:0] alpha;
  } pixel_out_t;

  typedef struct packed {
    logic       full_range;
    logic [1:0] matrix_select;
  } cfg_t;

  typedef struct packed {
    logic [CoefW-1:0] kr;
    logic [CoefW-1:0] kgu;
    logic [CoefW-1:0] kgv;
    logic [CoefW-1:0] kb;
  } coef_t;

  function automatic coef_t coef_lookup(input logic full, input logic [1:0] mat);
    coef_t k;
    if (full) begin
      case (mat)
        MAT_BT601:  k = '{10'd359, 10'd88, 10'd183, 10'd454};
        MAT_BT2020: k = '{10'd377, 10'd42, 10'd146, 10'd482};
        default:    k = '{10'd403, 10'd48, 10'd120, 10'd475};
      endcase
    end else begin
      case (mat)
        MAT_BT601:  k = '{10'd409, 10'd100, 10'd208, 10'd516};
        MAT_BT2020: k = '{10'd430, 10'd48, 10'd167, 10'd548};
        default:    k = '{10'd459, 10'd55, 10'd136, 10'd541};
      endcase
    end
    return k;
  endfunction

  function automatic logic [SampleW-1:0] sat_byte(input acc_t v);
    logic [SampleW-1:0] s;
    if (v < 0) begin
      s = '0;
    end else if (v > acc_t'(255)) begin
      s = '1;
    end else begin
      s = v[SampleW-1:0];
    end
    return s;
  endfunction

endpackage

// ===== design/ycc2rgb_if.sv =====
// ----------------------------------------------------------------------------
// ycc2rgb stream interfaces
// Valid/ready channels for the YCbCr input word and the RGBA result word.
// ----------------------------------------------------------------------------
interface ycc2rgb_in_if;
  import ycc2rgb_pkg::*;
  logic      valid;
  logic      ready;
  pixel_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ycc2rgb_out_if;
  import ycc2rgb_pkg::*;
  logic       valid;
  logic       ready;
  pixel_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ycbcr_to_rgba_pixel_converter_unit.sv =====
// ----------------------------------------------------------------------------
// ycbcr_to_rgba_pixel_converter_unit
// YCbCr 8-bit to RGBA 8-bit converter, full or limited range, three matrices.
// ----------------------------------------------------------------------------
// One pixel per clock: a word is taken into the input register, passes the
// constant-coefficient matrix and lands in the result register once that
// register can take it, and a new word is accepted every cycle while the
// result side keeps taking. Alpha is always 255.
// cfg_index 0 is full_range (reset 0), cfg_index 1 is matrix_select (reset 2,
// BT.709; code 3 also gives BT.709); change them only while no pixel is in flight.
module ycbcr_to_rgba_pixel_converter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  ycc2rgb_in_if.sink                    in_ch,
  ycc2rgb_out_if.source                 out_ch,
  input  logic                          cfg_we,
  input  logic [ycc2rgb_pkg::IndexW-1:0] cfg_index,
  input  logic [ycc2rgb_pkg::CfgW-1:0]   cfg_wdata
);
  import ycc2rgb_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic       s1_ready;
  pixel_in_t  s1_data;
  pixel_out_t s2_data;

  ycc2rgb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ycc2rgb_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready)
  );

  ycc2rgb_matrix u_matrix (
    .cfg     (cfg),
    .pix_in  (s1_data),
    .pix_out (s2_data)
  );

  ycc2rgb_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s1_valid),
    .s2_data  (s2_data),
    .s2_ready (s1_ready),
    .out_ch   (out_ch)
  );

endmodule

// ===== design/ycc2rgb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ycc2rgb_cfg_regs
// Range and matrix selection registers behind the plain write port.
// ----------------------------------------------------------------------------
module ycc2rgb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ycc2rgb_pkg::IndexW-1:0] cfg_index,
  input  logic [ycc2rgb_pkg::CfgW-1:0]   cfg_wdata,
  output ycc2rgb_pkg::cfg_t             cfg
);
  import ycc2rgb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_FULL_RANGE: cfg_nxt.full_range    = cfg_wdata[0];
        CFG_IDX_MATRIX:     cfg_nxt.matrix_select = cfg_wdata[1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_range    <= 1'b0;
      cfg_r.matrix_select <= MAT_BT709;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/ycc2rgb_in_stage.sv =====
// ----------------------------------------------------------------------------
// ycc2rgb_in_stage
// Input register for the YCbCr word, advances whenever the next stage can take.
// ----------------------------------------------------------------------------
module ycc2rgb_in_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  ycc2rgb_in_if.sink             in_ch,
  output logic                   s1_valid,
  output ycc2rgb_pkg::pixel_in_t s1_data,
  input  logic                   s1_ready
);
  import ycc2rgb_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  pixel_in_t data_r;
  logic      take;

  assign in_ch.ready = !valid_r || s1_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (s1_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_ch.data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

// ===== design/ycc2rgb_matrix.sv =====
// ----------------------------------------------------------------------------
// ycc2rgb_matrix
// Fixed-point color matrix with limited-range luma scaling and saturation.
// ----------------------------------------------------------------------------
module ycc2rgb_matrix (
  input  ycc2rgb_pkg::cfg_t       cfg,
  input  ycc2rgb_pkg::pixel_in_t  pix_in,
  output ycc2rgb_pkg::pixel_out_t pix_out
);
  import ycc2rgb_pkg::*;

  coef_t                     k;
  logic signed [SampleW-1:0] d;
  logic signed [SampleW-1:0] e;
  logic [SampleW-1:0]        c;
  acc_t                      y_s;
  acc_t                      c_term;
  acc_t                      base;
  acc_t                      r_prod;
  acc_t                      b_prod;
  acc_t                      g_sum;
  acc_t                      r_acc;
  acc_t                      b_acc;
  acc_t                      g_acc;

  assign k = coef_lookup(cfg.full_range, cfg.matrix_select);

  // chroma minus 128 is the byte with its top bit flipped
  assign d = $signed({~pix_in.chroma_blue[SampleW-1], pix_in.chroma_blue[SampleW-2:0]});
  assign e = $signed({~pix_in.chroma_red[SampleW-1], pix_in.chroma_red[SampleW-2:0]});

  assign c = (pix_in.luma < LUMA_FLOOR) ? '0 : pix_in.luma - LUMA_FLOOR;

  assign y_s    = acc_t'({{(AccW-SampleW){1'b0}}, pix_in.luma});
  assign c_term = acc_t'({{(AccW-CoefW){1'b0}}, LUMA_GAIN})
                * acc_t'({{(AccW-SampleW){1'b0}}, c});

  // full range folds y in above the shift, limited range adds the rounding term
  assign base = cfg.full_range ? (y_s <<< 8) : (c_term + acc_t'(128));

  assign r_prod = acc_t'({{(AccW-CoefW){1'b0}}, k.kr}) * acc_t'(e);
  assign b_prod = acc_t'({{(AccW-CoefW){1'b0}}, k.kb}) * acc_t'(d);
  assign g_sum  = acc_t'({{(AccW-CoefW){1'b0}}, k.kgu}) * acc_t'(d)
                + acc_t'({{(AccW-CoefW){1'b0}}, k.kgv}) * acc_t'(e);

  assign r_acc = (base + r_prod) >>> 8;
  assign b_acc = (base + b_prod) >>> 8;
  assign g_acc = cfg.full_range ? (y_s - (g_sum >>> 8)) : ((base - g_sum) >>> 8);

  assign pix_out.red   = sat_byte(r_acc);
  assign pix_out.green = sat_byte(g_acc);
  assign pix_out.blue  = sat_byte(b_acc);
  assign pix_out.alpha = ALPHA_OPAQUE;

endmodule

// ===== design/ycc2rgb_out_stage.sv =====
// ----------------------------------------------------------------------------
// ycc2rgb_out_stage
// Result register for the RGBA word, refilled in the cycle it is taken.
// ----------------------------------------------------------------------------
module ycc2rgb_out_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s2_valid,
  input  ycc2rgb_pkg::pixel_out_t s2_data,
  output logic                    s2_ready,
  ycc2rgb_out_if.source           out_ch
);
  import ycc2rgb_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  pixel_out_t data_r;
  logic       load;

  assign s2_ready = !valid_r || out_ch.ready;
  assign load     = s2_valid && s2_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= s2_data;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.data  = data_r;

endmodule

// ===== tb/sv/ycc2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// ycc2rgb_checker
// Watches the pixel channels and the register port of the YCbCr to RGBA
// converter. It keeps its own copy of the range and matrix registers and
// works out the RGBA word for every accepted YCbCr word with integer math.
// Result words are compared in order against the oldest pending pixel. The
// failure count and the number of pixels still in flight go to the top.
// ----------------------------------------------------------------------------
module ycc2rgb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  ycc2rgb_pkg::pixel_in_t         in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  ycc2rgb_pkg::pixel_out_t        out_data,
  input  logic                           cfg_we,
  input  logic [ycc2rgb_pkg::IndexW-1:0] cfg_index,
  input  logic [ycc2rgb_pkg::CfgW-1:0]   cfg_wdata,
  output int unsigned                    fail_count,
  output int unsigned                    pending_count
);
  import ycc2rgb_pkg::*;

  logic        full_q;
  logic [1:0]  mat_q;
  pixel_out_t  pending_rgba[$];
  int unsigned fails = 0;

  function automatic logic [SampleW-1:0] clamp_byte(input int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return v[SampleW-1:0];
  endfunction

  function automatic pixel_out_t convert_pixel(input pixel_in_t px, input logic full,
                                               input logic [1:0] mat);
    int kr, kgu, kgv, kb;
    int y, d, e, c, r, g, b;
    pixel_out_t rgba;
    y = int'(px.luma);
    d = int'(px.chroma_blue) - 128;
    e = int'(px.chroma_red) - 128;
    if (full) begin
      case (mat)
        MAT_BT601: begin
          kr = 359; kgu = 88; kgv = 183; kb = 454;
        end
        MAT_BT2020: begin
          kr = 377; kgu = 42; kgv = 146; kb = 482;
        end
        default: begin
          kr = 403; kgu = 48; kgv = 120; kb = 475;
        end
      endcase
      r = y + ((kr * e) >>> 8);
      g = y - ((kgu * d + kgv * e) >>> 8);
      b = y + ((kb * d) >>> 8);
    end else begin
      case (mat)
        MAT_BT601: begin
          kr = 409; kgu = 100; kgv = 208; kb = 516;
        end
        MAT_BT2020: begin
          kr = 430; kgu = 48; kgv = 167; kb = 548;
        end
        default: begin
          kr = 459; kgu = 55; kgv = 136; kb = 541;
        end
      endcase
      // studio luma floored at black
      c = (y > int'(LUMA_FLOOR)) ? y - int'(LUMA_FLOOR) : 0;
      r = (298 * c + kr * e + 128) >>> 8;
      g = (298 * c - kgu * d - kgv * e + 128) >>> 8;
      b = (298 * c + kb * d + 128) >>> 8;
    end
    rgba.red   = clamp_byte(r);
    rgba.green = clamp_byte(g);
    rgba.blue  = clamp_byte(b);
    rgba.alpha = ALPHA_OPAQUE;
    return rgba;
  endfunction

  task automatic compare_field(input string name, input logic [SampleW-1:0] want,
                               input logic [SampleW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : monitor
    pixel_out_t want;
    if (!rst_n) begin
      full_q = 1'b0;
      mat_q  = MAT_BT709;
      pending_rgba.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_rgba.size() == 0) begin
          $error("result word %h with no pixel pending", out_data);
          fails++;
        end else begin
          want = pending_rgba.pop_front();
          compare_field("red", want.red, out_data.red);
          compare_field("green", want.green, out_data.green);
          compare_field("blue", want.blue, out_data.blue);
          compare_field("alpha", want.alpha, out_data.alpha);
        end
      end
      if (in_valid && in_ready) begin
        pending_rgba.push_back(convert_pixel(in_data, full_q, mat_q));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_FULL_RANGE: full_q = cfg_wdata[0];
          CFG_IDX_MATRIX:     mat_q  = cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
    pending_count <= pending_rgba.size();
    fail_count    <= fails;
  end

endmodule

// ===== tb/sv/tb_ycbcr_to_rgba_pixel_converter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_ycbcr_to_rgba_pixel_converter_unit
// Drives corner and random YCbCr words through the converter under every
// range and matrix setting, with random gaps on both channels, a long
// result-side hold-off and a mid-stream drain. Unused register indexes are
// written too. The checker beside the block decides pass or fail.
// ----------------------------------------------------------------------------
module tb_ycbcr_to_rgba_pixel_converter_unit;
  import ycc2rgb_pkg::*;

  localparam int          PhaseCount    = 8;
  localparam int          ItemsPerPhase = 170;
  localparam int          HoldCycles    = 80;
  localparam int unsigned CycleLimit    = 400000;

  localparam logic [IndexW-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [IndexW-1:0] CFG_IDX_SPARE_HI = 2'd3;
  localparam logic [1:0]        MAT_UNUSED       = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IndexW-1:0] cfg_index;
  logic [CfgW-1:0]   cfg_wdata;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned hold_left = 0;
  bit          gaps_on = 1'b1;
  bit          hold_go = 1'b0;

  ycc2rgb_in_if  in_ch ();
  ycc2rgb_out_if out_ch ();

  ycbcr_to_rgba_pixel_converter_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ycc2rgb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !gaps_on || ($urandom_range(99) >= 26);
    end
  end

  function automatic logic [SampleW-1:0] pick_sample();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(4))
        0: return '0;
        1: return '1;
        2: return LUMA_FLOOR;
        3: return LUMA_FLOOR - 8'd1;
        default: return 8'd128;
      endcase
    end
    return SampleW'($urandom_range(255));
  endfunction

  task automatic send_pixel(input pixel_in_t px);
    while (gaps_on && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_cfg(input logic full, input logic [1:0] mat);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_FULL_RANGE;
    cfg_wdata <= {1'($urandom_range(1)), full};
    @(posedge clk);
    cfg_index <= CFG_IDX_MATRIX;
    cfg_wdata <= mat;
    @(posedge clk);
    // spare index, must leave the settings alone
    cfg_index <= $urandom_range(1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI;
    cfg_wdata <= CfgW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    pixel_in_t   corner_px[$];
    logic        full_sel[PhaseCount];
    logic [1:0]  mat_sel[PhaseCount];
    pixel_in_t   px;

    corner_px.push_back('{8'd0, 8'd0, 8'd0});
    corner_px.push_back('{8'd255, 8'd255, 8'd255});
    corner_px.push_back('{8'd0, 8'd255, 8'd0});
    corner_px.push_back('{8'd255, 8'd0, 8'd255});
    corner_px.push_back('{8'd255, 8'd0, 8'd0});
    corner_px.push_back('{8'd0, 8'd255, 8'd255});
    corner_px.push_back('{8'd15, 8'd128, 8'd128});
    corner_px.push_back('{8'd16, 8'd128, 8'd128});
    corner_px.push_back('{8'd235, 8'd240, 8'd240});
    corner_px.push_back('{8'd128, 8'd16, 8'd16});
    corner_px.push_back('{8'd128, 8'd128, 8'd128});
    corner_px.push_back('{8'd255, 8'd128, 8'd0});

    full_sel = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    mat_sel  = '{MAT_BT2020, MAT_BT709, MAT_UNUSED, MAT_BT601,
                 MAT_BT2020, MAT_UNUSED, MAT_BT709, MAT_BT601};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners at reset settings, then full range bt.601
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    drain();
    program_cfg(1'b1, MAT_BT601);
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      program_cfg(full_sel[p], mat_sel[p]);
      gaps_on = (p != 1);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (p == 2 && i == 20) hold_go = 1'b1;
        if (p == 4 && i == 90) drain();
        px.luma        = pick_sample();
        px.chroma_blue = pick_sample();
        px.chroma_red  = pick_sample();
        send_pixel(px);
      end
      drain();
    end
    gaps_on = 1'b1;

    $display("converted %0d pixels: corners plus random words under both ranges",
             sent_count);
    $display("and all four matrix codes, with spare register writes and stalls");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
